>>> rtl/core/pcmt_pkg.sv
// shared types and codes for the priority collection max table
// request and status codes, store control and result structs
// no dependencies
package pcmt_pkg;

	localparam logic [2:0] REQ_ADD     = 3'd0;
	localparam logic [2:0] REQ_PROMOTE = 3'd1;
	localparam logic [2:0] REQ_GETMAX  = 3'd2;
	localparam logic [2:0] REQ_POPMAX  = 3'd3;
	localparam logic [2:0] REQ_ISVALID = 3'd4;
	localparam logic [2:0] REQ_GET     = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic rd_en;
		logic meta_we;
		logic pay_we;
	} store_ctl_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  id;
		logic [31:0] payload;
		logic [15:0] prio;
		logic        live;
	} result_t;

endpackage

>>> rtl/core/pcmt_store.sv
// entry store: live flag and priority memory plus payload memory
// one write port and one registered read port per memory
// depends on pcmt_pkg
module pcmt_store #(
	parameter int MAX_ENTRIES   = 256,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 16,
	localparam int IDW = $clog2(MAX_ENTRIES)
) (
	input  logic                     clk,
	input  pcmt_pkg::store_ctl_t     ctl,
	input  logic [IDW-1:0]           rd_addr,
	input  logic [IDW-1:0]           wr_addr,
	input  logic                     wr_live,
	input  logic [PRIORITY_BITS-1:0] wr_pri,
	input  logic [PAYLOAD_BITS-1:0]  wr_payload,
	output logic                     rd_live,
	output logic [PRIORITY_BITS-1:0] rd_pri,
	output logic [PAYLOAD_BITS-1:0]  rd_payload
);
	import pcmt_pkg::*;

	logic [PRIORITY_BITS:0]   meta_mem [MAX_ENTRIES];
	logic [PAYLOAD_BITS-1:0]  pay_mem  [MAX_ENTRIES];
	logic [PRIORITY_BITS:0]   meta_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;

	always_ff @(posedge clk) begin
		if (ctl.meta_we) begin
			meta_mem[wr_addr] <= {wr_live, wr_pri};
		end
		if (ctl.rd_en) begin
			meta_q <= meta_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pay_we) begin
			pay_mem[wr_addr] <= wr_payload;
		end
		if (ctl.rd_en) begin
			pay_q <= pay_mem[rd_addr];
		end
	end

	assign rd_live    = meta_q[PRIORITY_BITS];
	assign rd_pri     = meta_q[PRIORITY_BITS-1:0];
	assign rd_payload = pay_q;

endmodule

>>> rtl/core/pcmt_seq.sv
// request sequencer with the shared compare and increment unit
// walks the entry store one id per cycle for max searches
// depends on pcmt_pkg
module pcmt_seq #(
	parameter int MAX_ENTRIES   = 256,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 16,
	localparam int IDW = $clog2(MAX_ENTRIES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               req_type,
	input  logic [7:0]               entry_id,
	input  logic [31:0]              payload_in,
	output pcmt_pkg::store_ctl_t     st_ctl,
	output logic [IDW-1:0]           st_rd_addr,
	output logic [IDW-1:0]           st_wr_addr,
	output logic                     st_wr_live,
	output logic [PRIORITY_BITS-1:0] st_wr_pri,
	output logic [PAYLOAD_BITS-1:0]  st_wr_payload,
	input  logic                     st_rd_live,
	input  logic [PRIORITY_BITS-1:0] st_rd_pri,
	input  logic [PAYLOAD_BITS-1:0]  st_rd_payload,
	output logic                     res_valid,
	output pcmt_pkg::result_t        res,
	input  logic                     res_take
);
	import pcmt_pkg::*;

	localparam int CW = (IDW + 1 > 8) ? IDW + 1 : 9;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]               state_q, state_d;
	logic [IDW:0]             fresh_q, fresh_d;
	logic [IDW-1:0]           rid_q, rid_d;
	logic                     found_q, found_d;
	logic [IDW-1:0]           best_q, best_d;
	logic [PRIORITY_BITS-1:0] best_pri_q, best_pri_d;
	logic [2:0]               req_q;
	logic [7:0]               id_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;
	result_t                  res_q, res_d;

	logic                     full;
	logic                     id_ok;
	logic                     take;
	logic                     last;
	logic [IDW-1:0]           new_best;
	logic [PRIORITY_BITS-1:0] pri_inc;

	// shared unit: one compare against the running best, one saturating increment
	assign full     = (fresh_q == (IDW + 1)'(MAX_ENTRIES));
	assign id_ok    = (CW'(id_q) < CW'(fresh_q));
	assign take     = st_rd_live && (!found_q || (st_rd_pri >= best_pri_q));
	assign new_best = take ? rid_q : best_q;
	assign last     = (((IDW + 1)'(rid_q) + (IDW + 1)'(1)) == fresh_q);
	assign pri_inc  = (&st_rd_pri) ? st_rd_pri : st_rd_pri + 1'b1;

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		state_d       = state_q;
		fresh_d       = fresh_q;
		rid_d         = rid_q;
		found_d       = found_q;
		best_d        = best_q;
		best_pri_d    = best_pri_q;
		res_d         = res_q;
		st_ctl        = '0;
		st_rd_addr    = '0;
		st_wr_addr    = '0;
		st_wr_live    = 1'b0;
		st_wr_pri     = '0;
		st_wr_payload = pay_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				res_d   = '{status: ST_OK, id: 8'd0, payload: 32'd0, prio: 16'd0,
					live: 1'b0};
				case (req_q)
					REQ_ADD: begin
						if (full) begin
							res_d.status = ST_FULL;
						end else begin
							st_ctl.meta_we = 1'b1;
							st_ctl.pay_we  = 1'b1;
							st_wr_addr     = fresh_q[IDW-1:0];
							st_wr_live     = 1'b1;
							res_d.id       = 8'(fresh_q);
							res_d.payload  = 32'(pay_q);
							res_d.live     = 1'b1;
							fresh_d        = fresh_q + 1'b1;
						end
					end
					REQ_PROMOTE, REQ_GET, REQ_ISVALID: begin
						res_d.id = id_q;
						if (id_ok) begin
							st_ctl.rd_en = 1'b1;
							st_rd_addr   = IDW'(id_q);
							state_d      = S_LOOK;
						end else if (req_q != REQ_ISVALID) begin
							res_d.status = ST_INVALID;
						end
					end
					REQ_GETMAX, REQ_POPMAX: begin
						if (fresh_q == '0) begin
							res_d.status = ST_EMPTY;
						end else begin
							st_ctl.rd_en = 1'b1;
							rid_d        = '0;
							found_d      = 1'b0;
							state_d      = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_LOOK: begin
				state_d = S_DONE;
				res_d   = '{status: ST_OK, id: id_q, payload: 32'd0, prio: 16'd0,
					live: 1'b0};
				if (st_rd_live) begin
					res_d.payload = 32'(st_rd_payload);
					res_d.live    = 1'b1;
					if (req_q == REQ_PROMOTE) begin
						st_ctl.meta_we = 1'b1;
						st_wr_addr     = IDW'(id_q);
						st_wr_live     = 1'b1;
						st_wr_pri      = pri_inc;
						res_d.prio     = 16'(pri_inc);
					end else begin
						res_d.prio = 16'(st_rd_pri);
					end
				end else if (req_q != REQ_ISVALID) begin
					res_d.status = ST_INVALID;
				end
			end
			S_SCAN: begin
				found_d      = found_q | take;
				best_d       = new_best;
				best_pri_d   = take ? st_rd_pri : best_pri_q;
				st_ctl.rd_en = 1'b1;
				if (last) begin
					// read the winner back for its payload
					st_rd_addr = new_best;
					if (found_q || take) begin
						state_d = S_FETCH;
					end else begin
						res_d   = '{status: ST_EMPTY, id: 8'd0, payload: 32'd0,
							prio: 16'd0, live: 1'b0};
						state_d = S_DONE;
					end
				end else begin
					st_rd_addr = rid_q + 1'b1;
					rid_d      = rid_q + 1'b1;
				end
			end
			S_FETCH: begin
				res_d   = '{status: ST_OK, id: 8'(best_q), payload: 32'(st_rd_payload),
					prio: 16'(st_rd_pri), live: 1'b1};
				state_d = S_DONE;
				if (req_q == REQ_POPMAX) begin
					st_ctl.meta_we = 1'b1;
					st_wr_addr     = best_q;
					st_wr_live     = 1'b0;
					st_wr_pri      = st_rd_pri;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fresh_q <= '0;
			rid_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fresh_q <= fresh_d;
			rid_q   <= rid_d;
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		best_q     <= best_d;
		best_pri_q <= best_pri_d;
		res_q      <= res_d;
		if (state_q == S_IDLE && in_valid) begin
			req_q <= req_type;
			id_q  <= entry_id;
			pay_q <= PAYLOAD_BITS'(payload_in);
		end
	end

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= (IDW + 1)'(MAX_ENTRIES))
		else $error("fresh id count beyond table size");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		st_ctl.meta_we |-> (state_q == S_DISP || state_q == S_LOOK || state_q == S_FETCH))
		else $error("entry store written outside a request step");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((IDW + 1)'(rid_q) < fresh_q))
		else $error("scan reached an id never issued");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP && req_q == REQ_ADD && !full)
		|=> (fresh_q == (IDW + 1)'($past(fresh_q) + 1'b1)))
		else $error("add did not advance the fresh id");

endmodule

>>> rtl/core/priority_collection_max_table_unit.sv
// top level of the priority collection max table
// holds the result register and joins the sequencer to the entry store
// depends on pcmt_pkg, pcmt_store, pcmt_seq
//
//  channel | signals                                       | transfer when
//  --------+-----------------------------------------------+----------------------
//  request | in_valid, in_stall, req_type, entry_id,       | in_valid & !in_stall
//          | payload_in                                    |
//  result  | out_valid, out_stall, status, result_id,      | out_valid & !out_stall
//          | payload_out, priority_out, is_live            |
//
// add and unknown requests pass through dispatch to done; promote, is valid and get
//   also pass through a lookup, which is skipped when the id was never issued
// get max and pop max scan and then fetch the winner, skipping the fetch when no entry is
//   live: the single read port of the entry store is stepped one id per cycle
//   through every issued id
// one request at a time: in_stall is high from transfer until the result is loaded
// the result register lets a new request in while the last result waits on out_stall
// reset clears control and the fresh id count; stores are gated by the fresh id count
module priority_collection_max_table_unit #(
	parameter int MAX_ENTRIES   = 256,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  entry_id,
	input  logic [31:0] payload_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  result_id,
	output logic [31:0] payload_out,
	output logic [15:0] priority_out,
	output logic        is_live
);
	import pcmt_pkg::*;

	localparam int IDW = $clog2(MAX_ENTRIES);

	store_ctl_t               st_ctl;
	logic [IDW-1:0]           st_rd_addr;
	logic [IDW-1:0]           st_wr_addr;
	logic                     st_wr_live;
	logic [PRIORITY_BITS-1:0] st_wr_pri;
	logic [PAYLOAD_BITS-1:0]  st_wr_payload;
	logic                     st_rd_live;
	logic [PRIORITY_BITS-1:0] st_rd_pri;
	logic [PAYLOAD_BITS-1:0]  st_rd_payload;

	logic                     res_valid;
	result_t                  res;
	logic                     res_take;

	logic                     out_valid_q;
	result_t                  out_q;

	// entry store: live flags, priorities and payloads
	pcmt_store #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.PAYLOAD_BITS  (PAYLOAD_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_store (
		.clk        (clk),
		.ctl        (st_ctl),
		.rd_addr    (st_rd_addr),
		.wr_addr    (st_wr_addr),
		.wr_live    (st_wr_live),
		.wr_pri     (st_wr_pri),
		.wr_payload (st_wr_payload),
		.rd_live    (st_rd_live),
		.rd_pri     (st_rd_pri),
		.rd_payload (st_rd_payload)
	);

	// sequencer and shared compare unit
	pcmt_seq #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.PAYLOAD_BITS  (PAYLOAD_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.entry_id      (entry_id),
		.payload_in    (payload_in),
		.st_ctl        (st_ctl),
		.st_rd_addr    (st_rd_addr),
		.st_wr_addr    (st_wr_addr),
		.st_wr_live    (st_wr_live),
		.st_wr_pri     (st_wr_pri),
		.st_wr_payload (st_wr_payload),
		.st_rd_live    (st_rd_live),
		.st_rd_pri     (st_rd_pri),
		.st_rd_payload (st_rd_payload),
		.res_valid     (res_valid),
		.res           (res),
		.res_take      (res_take)
	);

	// result register is free when empty or being drained this cycle
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload of the result register, held while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign result_id    = out_q.id;
	assign payload_out  = out_q.payload;
	assign priority_out = out_q.prio;
	assign is_live      = out_q.live;

endmodule

>>> dv/priority_collection_max_table_unit_tb.sv
// self-checking testbench for priority_collection_max_table_unit
// directed table then weighted random requests, checked against a shadow table
// depends on pcmt_pkg and the rtl top level only
`timescale 1ns / 100ps

module priority_collection_max_table_unit_tb;
	import pcmt_pkg::*;

	// table geometry as built into the block
	localparam int         TABLE_DEPTH = 256;
	localparam logic [15:0] PRIO_TOP   = 16'hFFFF;
	localparam int         NO_ENTRY    = -1;

	// request codes the block does not define, answered with a blank ok
	localparam logic [2:0] REQ_RSVD_A = 3'd6;
	localparam logic [2:0] REQ_RSVD_B = 3'd7;

	// directed rows either carry a hand-written answer or defer to the shadow table
	localparam bit TYPED     = 1'b1;
	localparam bit PREDICTED = 1'b0;

	// run shape
	localparam int N_RANDOM       = 1325;
	localparam int PRESSURE_AT    = 525;  // transfers before the long receiver hold
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [2:0]  req;
		logic [7:0]  id;
		logic [31:0] pay;
		bit          typed;
		result_t     want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [7:0]  entry_id;
	logic [31:0] payload_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  result_id;
	logic [31:0] payload_out;
	logic [15:0] priority_out;
	logic        is_live;

	// shadow of the entry table, updated at every request transfer
	logic [15:0] shadow_prio    [TABLE_DEPTH];
	logic [31:0] shadow_payload [TABLE_DEPTH];
	bit          shadow_live    [TABLE_DEPTH];
	int unsigned ids_issued;

	// answers owed by the block, oldest first
	result_t answers_due [$];
	stim_row_t directed_rows [$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned sent_total;
	int unsigned mismatch_count;
	int unsigned req_count [8];
	int unsigned status_seen [4];
	logic [15:0] top_prio_seen;

	priority_collection_max_table_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.entry_id     (entry_id),
		.payload_in   (payload_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_id    (result_id),
		.payload_out  (payload_out),
		.priority_out (priority_out),
		.is_live      (is_live)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one line per mismatch, and a running count
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// answer of the table to one request, with the shadow state moved on
	function automatic result_t table_answer(input logic [2:0] req, input logic [7:0] id,
	                                         input logic [31:0] pay);
		result_t ans;
		int best;
		ans = '0;
		best = NO_ENTRY;
		case (req)
			REQ_ADD: begin
				if (ids_issued >= TABLE_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					shadow_payload[ids_issued] = pay;
					shadow_prio[ids_issued] = '0;
					shadow_live[ids_issued] = 1'b1;
					ans.status = ST_OK;
					ans.id = ids_issued[7:0];
					ans.payload = pay;
					ans.live = 1'b1;
					ids_issued++;
				end
			end
			REQ_PROMOTE: begin
				if (!shadow_live[id]) begin
					ans.status = ST_INVALID;
					ans.id = id;
				end else begin
					// saturates at the top value
					if (shadow_prio[id] != PRIO_TOP) shadow_prio[id]++;
					ans.status = ST_OK;
					ans.id = id;
					ans.payload = shadow_payload[id];
					ans.prio = shadow_prio[id];
					ans.live = 1'b1;
				end
			end
			REQ_GETMAX, REQ_POPMAX: begin
				// >= so that ties go to the largest id
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (shadow_live[i] && (best == NO_ENTRY || shadow_prio[i] >= shadow_prio[best]))
						best = i;
				end
				if (best == NO_ENTRY) begin
					ans.status = ST_EMPTY;
				end else begin
					ans.status = ST_OK;
					ans.id = best[7:0];
					ans.payload = shadow_payload[best];
					ans.prio = shadow_prio[best];
					ans.live = 1'b1;
					if (req == REQ_POPMAX) shadow_live[best] = 1'b0;
				end
			end
			REQ_ISVALID, REQ_GET: begin
				ans.id = id;
				if (shadow_live[id]) begin
					ans.status = ST_OK;
					ans.payload = shadow_payload[id];
					ans.prio = shadow_prio[id];
					ans.live = 1'b1;
				end else begin
					ans.status = (req == REQ_GET) ? ST_INVALID : ST_OK;
				end
			end
			default: begin
				ans = '0;
			end
		endcase
		return ans;
	endfunction

	// mostly live ids, some retired ones, some anywhere in the id space
	function automatic logic [7:0] pick_id();
		int unsigned roll;
		int unsigned start;
		int unsigned cand;
		roll = $urandom_range(99);
		if (roll < 80 && ids_issued != 0) begin
			start = $urandom_range(ids_issued - 1);
			for (int unsigned k = 0; k < ids_issued; k++) begin
				cand = (start + k) % ids_issued;
				if (shadow_live[cand]) return cand[7:0];
			end
		end
		if (roll < 92 && ids_issued != 0) return 8'($urandom_range(ids_issued - 1));
		return 8'($urandom_range(255));
	endfunction

	// offer one request and hold it until the transfer, then book its answer
	task automatic send_req(input logic [2:0] req, input logic [7:0] id, input logic [31:0] pay,
	                        input bit typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		entry_id   <= id;
		payload_in <= pay;
		do @(posedge clk); while (in_stall);
		// shadow state moves on in this process so the next pick sees it
		predicted = table_answer(req, id, pay);
		answers_due = {answers_due, (typed ? want : predicted)};
		sent_total++;
		req_count[req]++;
	endtask

	task automatic add_directed(input logic [2:0] req, input logic [7:0] id,
	                            input logic [31:0] pay, input bit typed, input logic [1:0] st,
	                            input logic [7:0] rid, input logic [31:0] rpay,
	                            input logic [15:0] rprio, input logic rlive);
		stim_row_t row;
		row.req = req;
		row.id = id;
		row.pay = pay;
		row.typed = typed;
		row.want.status = st;
		row.want.id = rid;
		row.want.payload = rpay;
		row.want.prio = rprio;
		row.want.live = rlive;
		directed_rows = {directed_rows, row};
	endtask

	// weighted request mix; once the ids run out, pops take over to drain the table
	task automatic send_random_req();
		int unsigned roll;
		int unsigned pay_roll;
		logic [2:0]  req;
		logic [31:0] pay;
		roll = $urandom_range(99);
		if (ids_issued < TABLE_DEPTH) begin
			if (roll < 30) req = REQ_ADD;
			else if (roll < 55) req = REQ_PROMOTE;
			else if (roll < 65) req = REQ_GETMAX;
			else if (roll < 80) req = REQ_POPMAX;
			else if (roll < 88) req = REQ_ISVALID;
			else if (roll < 96) req = REQ_GET;
			else req = $urandom_range(1) ? REQ_RSVD_B : REQ_RSVD_A;
		end else begin
			if (roll < 10) req = REQ_ADD;
			else if (roll < 35) req = REQ_PROMOTE;
			else if (roll < 45) req = REQ_GETMAX;
			else if (roll < 80) req = REQ_POPMAX;
			else if (roll < 88) req = REQ_ISVALID;
			else if (roll < 96) req = REQ_GET;
			else req = $urandom_range(1) ? REQ_RSVD_B : REQ_RSVD_A;
		end
		pay_roll = $urandom_range(99);
		if (pay_roll < 5) pay = '0;
		else if (pay_roll < 10) pay = '1;
		else pay = $urandom;
		send_req(req, pick_id(), pay, PREDICTED, '0);
	endtask

	// receiver: random stalls, plus one long hold while the sender keeps offering
	initial begin : result_sink
		int unsigned hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && sent_total >= PRESSURE_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// result check against the oldest booked answer, plus the no-progress watchdog
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		int unsigned quiet_cycles;
		got.status = status;
		got.id = result_id;
		got.payload = payload_out;
		got.prio = priority_out;
		got.live = is_live;
		if (arst_n && out_valid && !out_stall) begin
			status_seen[got.status]++;
			if (got.live && got.prio > top_prio_seen) top_prio_seen = got.prio;
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("result transfer with no request outstanding"));
			end else begin
				want = answers_due.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.id !== want.id)
					report_mismatch($sformatf("result_id %0d, expected %0d", got.id, want.id));
				if (got.payload !== want.payload)
					report_mismatch($sformatf("payload_out %h, expected %h",
						got.payload, want.payload));
				if (got.prio !== want.prio)
					report_mismatch($sformatf("priority_out %0d, expected %0d",
						got.prio, want.prio));
				if (got.live !== want.live)
					report_mismatch($sformatf("is_live %0d, expected %0d", got.live, want.live));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d answers outstanding",
					quiet_cycles, answers_due.size());
				$display("[priority_collection_max_table_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		entry_id = '0;
		payload_in = '0;
		ids_issued = 0;
		sent_total = 0;
		mismatch_count = 0;
		top_prio_seen = '0;
		tx_idle_pct = 31;
		rx_idle_pct = 65;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, unissued ids, unknown codes, then a small add/promote/pop story
		add_directed(REQ_GETMAX,  8'd0,   32'h0,        TYPED, ST_EMPTY,   8'd0,   32'h0, 16'd0, 1'b0);
		add_directed(REQ_POPMAX,  8'd0,   32'h0,        TYPED, ST_EMPTY,   8'd0,   32'h0, 16'd0, 1'b0);
		add_directed(REQ_PROMOTE, 8'd0,   32'h0,        TYPED, ST_INVALID, 8'd0,   32'h0, 16'd0, 1'b0);
		add_directed(REQ_GET,     8'd255, 32'h0,        TYPED, ST_INVALID, 8'd255, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_ISVALID, 8'd255, 32'hFFFFFFFF, TYPED, ST_OK,      8'd255, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_RSVD_A,  8'd255, 32'hFFFFFFFF, TYPED, ST_OK,      8'd0,   32'h0, 16'd0, 1'b0);
		add_directed(REQ_RSVD_B,  8'd170, 32'h55555555, TYPED, ST_OK,      8'd0,   32'h0, 16'd0, 1'b0);
		add_directed(REQ_ADD,     8'd255, 32'hFFFFFFFF, TYPED, ST_OK, 8'd0, 32'hFFFFFFFF, 16'd0, 1'b1);
		add_directed(REQ_ADD,     8'd0,   32'h0,        TYPED, ST_OK, 8'd1, 32'h0,        16'd0, 1'b1);
		add_directed(REQ_ADD,     8'd0,   32'hA5A5A5A5, TYPED, ST_OK, 8'd2, 32'hA5A5A5A5, 16'd0, 1'b1);
		// all at priority zero: the tie goes to the largest id
		add_directed(REQ_GETMAX,  8'd0,   32'h0,        TYPED, ST_OK, 8'd2, 32'hA5A5A5A5, 16'd0, 1'b1);
		add_directed(REQ_PROMOTE, 8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_PROMOTE, 8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_PROMOTE, 8'd1,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_GETMAX,  8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_ISVALID, 8'd1,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_GET,     8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_POPMAX,  8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		// id 0 has just been retired
		add_directed(REQ_GET,     8'd0,   32'h0,        TYPED, ST_INVALID, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_PROMOTE, 8'd0,   32'h0,        TYPED, ST_INVALID, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_ISVALID, 8'd0,   32'h0,        TYPED, ST_OK,      8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_POPMAX,  8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_POPMAX,  8'd0,   32'h0, PREDICTED, ST_OK, 8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_POPMAX,  8'd0,   32'h0,        TYPED, ST_EMPTY,   8'd0, 32'h0, 16'd0, 1'b0);
		add_directed(REQ_GETMAX,  8'd0,   32'h0,        TYPED, ST_EMPTY,   8'd0, 32'h0, 16'd0, 1'b0);

		foreach (directed_rows[r]) begin
			send_req(directed_rows[r].req, directed_rows[r].id, directed_rows[r].pay,
				directed_rows[r].typed, directed_rows[r].want);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// swap which side is the slow one, then run with no idling at all
			if (n == N_RANDOM / 3) begin
				tx_idle_pct = 65;
				rx_idle_pct = 31;
			end
			if (n == 2 * N_RANDOM / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send_random_req();
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// let every owed answer arrive, then watch for strays
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d adds (%0d refused as full), %0d promotes, %0d max reads",
			sent_total, req_count[REQ_ADD], status_seen[ST_FULL], req_count[REQ_PROMOTE],
			req_count[REQ_GETMAX] + req_count[REQ_POPMAX]);
		$display("%0d empty and %0d invalid-id answers, highest priority reported %0d",
			status_seen[ST_EMPTY], status_seen[ST_INVALID], top_prio_seen);
		if (mismatch_count == 0) begin
			$display("[priority_collection_max_table_unit] OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("[priority_collection_max_table_unit] ERROR");
		end
		$finish;
	end

endmodule

>>> priority_collection_max_table_unit.f
rtl/core/pcmt_pkg.sv
rtl/core/pcmt_store.sv
rtl/core/pcmt_seq.sv
rtl/core/priority_collection_max_table_unit.sv
dv/priority_collection_max_table_unit_tb.sv
